@@ design/sph_pkg.sv @@
// ----------------------------------------------------------------------------
// sph_pkg: shared types, constants and wide multiply helper
// Request/response structs, wide word sizing and the limb multiplier split.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package sph_pkg;

  localparam int FRAC_BITS = 16;
  localparam int HW        = 31;                  // radius width
  localparam int NLANE     = 3;
  localparam int NSTEP     = 3;                   // numerator multiply steps
  localparam int DIV_STEPS = 33;                  // quotient bits incl. overflow
  localparam int DIV_LAT   = DIV_STEPS + 2;

  // numerator bound: 45 * |d| * u^3 << (frac*7+60), denominator r*pi*h^6
  localparam int NW = 6 + 32 + 3 * HW + 7 * FRAC_BITS + 60;
  localparam int DW = HW + 62 + 6 * HW;
  localparam int DQ = DW + DIV_STEPS;
  localparam int RW = (NW > DQ) ? NW : DQ;
  localparam int NL = (RW + 31) / 32;
  localparam int WW = NL * 32;

  localparam int SH0 = FRAC_BITS * 7 + 60;
  localparam int SH2 = FRAC_BITS * 5 + 60;
  localparam int SH3 = FRAC_BITS * 4 + 60;

  localparam logic [HW-1:0] RADIUS_RST = HW'(65536);
  localparam logic [63:0]   PI_Q60     = 64'h3243_F6A8_885A_308D;
  localparam logic [5:0]    K_VALUE    = 6'd15;
  localparam logic [5:0]    K_DERIV    = 6'd45;
  localparam logic [31:0]   SAT_POS    = 32'h7FFF_FFFF;
  localparam logic [31:0]   SAT_NEG    = 32'h8000_0000;

  typedef enum logic [1:0] {
    OP_VALUE = 2'd0,
    OP_GRAD  = 2'd1,
    OP_LAP   = 2'd2
  } op_e;

  typedef logic [WW-1:0] wide_t;

  localparam wide_t PI_W = wide_t'(PI_Q60);

  typedef struct packed {
    logic [1:0]         opcode;
    logic signed [31:0] src_x;
    logic signed [31:0] src_y;
    logic signed [31:0] src_z;
    logic signed [31:0] dst_x;
    logic signed [31:0] dst_y;
    logic signed [31:0] dst_z;
  } req_t;

  typedef struct packed {
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
  } rsp_t;

  // classified request, front to back
  typedef struct packed {
    logic [1:0]              npow;
    logic                    k45;
    logic                    flip;
    logic                    zero;
    logic [NLANE-1:0]        neg;
    logic [NLANE-1:0][HW-1:0] mag;
  } item_t;

  typedef struct packed {
    wide_t ev;
    wide_t od;
  } wpart_t;

  // limb products of a * b; even and odd limbs never overlap, so one add
  // of the two words finishes the product
  function automatic wpart_t wmul_split(input wide_t a, input logic [31:0] b);
    logic [WW+63:0] ev;
    logic [WW+63:0] od;
    logic [63:0]    p;
    wpart_t         r;
    ev = '0;
    od = '0;
    for (int k = 0; k < NL; k++) begin
      p = a[32*k +: 32] * b;
      if ((k & 1) == 0) begin
        ev[32*k +: 64] = p;
      end else begin
        od[32*k +: 64] = p;
      end
    end
    r.ev = ev[WW-1:0];
    r.od = od[WW-1:0];
    return r;
  endfunction

endpackage

`default_nettype wire

@@ design/sph_front.sv @@
// ----------------------------------------------------------------------------
// sph_front: request intake and classification
// Forms the differences and magnitudes, range checks them and decodes the op.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sph_front (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [sph_pkg::HW-1:0]     radius_i,
  input  logic                       start_i,
  input  sph_pkg::req_t              req_i,
  input  logic                       q_full_i,
  output logic                       busy_o,
  output logic                       push_o,
  output sph_pkg::item_t             item_o
);

  logic           vld_q;
  sph_pkg::item_t item_q;
  sph_pkg::item_t item_d;
  logic           accept;

  logic signed [31:0] src [sph_pkg::NLANE];
  logic signed [31:0] dst [sph_pkg::NLANE];

  assign src[0] = req_i.src_x;
  assign src[1] = req_i.src_y;
  assign src[2] = req_i.src_z;
  assign dst[0] = req_i.dst_x;
  assign dst[1] = req_i.dst_y;
  assign dst[2] = req_i.dst_z;

  assign busy_o = vld_q && q_full_i;
  assign push_o = vld_q && !q_full_i;
  assign accept = start_i && !busy_o;
  assign item_o = item_q;

  always_comb begin
    logic [32:0] d;
    logic [32:0] a;
    logic        far;
    item_d = '0;
    far    = 1'b0;
    for (int c = 0; c < sph_pkg::NLANE; c++) begin
      d = {src[c][31], src[c]} - {dst[c][31], dst[c]};
      a = d[32] ? (~d + 33'd1) : d;
      item_d.neg[c] = d[32];
      item_d.mag[c] = a[sph_pkg::HW-1:0];
      if (a > 33'(radius_i)) begin
        far = 1'b1;
      end
    end
    case (sph_pkg::op_e'(req_i.opcode))
      sph_pkg::OP_VALUE: begin
        item_d.npow = 2'd3;
        item_d.k45  = 1'b0;
        item_d.flip = 1'b0;
        item_d.zero = far;
      end
      sph_pkg::OP_GRAD: begin
        item_d.npow = 2'd2;
        item_d.k45  = 1'b1;
        item_d.flip = 1'b1;
        item_d.zero = far;
      end
      sph_pkg::OP_LAP: begin
        item_d.npow = 2'd0;
        item_d.k45  = 1'b1;
        item_d.flip = 1'b0;
        item_d.zero = far;
      end
      default: begin
        item_d.zero = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (accept) begin
      vld_q <= 1'b1;
    end else if (push_o) begin
      vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= item_d;
    end
  end

endmodule

`default_nettype wire

@@ design/sph_queue.sv @@
// ----------------------------------------------------------------------------
// sph_queue: two-entry queue between front and back
// The back drains one entry per cycle whenever one is present.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sph_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  sph_pkg::item_t item_i,
  output logic           full_o,
  output logic           valid_o,
  output sph_pkg::item_t item_o
);

  sph_pkg::item_t mem_q [2];
  logic           wp_q;
  logic           rp_q;
  logic [1:0]     cnt_q;
  logic [1:0]     cnt_d;
  logic           pop;

  assign valid_o = (cnt_q != 2'd0);
  assign full_o  = (cnt_q == 2'd2);
  assign pop     = valid_o;
  assign item_o  = mem_q[rp_q];

  always_comb begin
    case ({push_i, pop})
      2'b10:   cnt_d = cnt_q + 2'd1;
      2'b01:   cnt_d = cnt_q - 2'd1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) begin
        wp_q <= ~wp_q;
      end
      if (pop) begin
        rp_q <= ~rp_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wp_q] <= item_i;
    end
  end

endmodule

`default_nettype wire

@@ design/sph_div.sv @@
// ----------------------------------------------------------------------------
// sph_div: pipelined restoring divider, one quotient bit per stage
// Top quotient bit flags overflow; output is saturated and signed.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sph_div (
  input  logic                clk_i,
  input  sph_pkg::wide_t      num_i,
  input  sph_pkg::wide_t      den_i,
  input  logic                sneg_i,
  input  logic                zero_i,
  output logic [31:0]         res_o
);

  localparam int NS = sph_pkg::DIV_STEPS;

  sph_pkg::wide_t  rem_q [NS+1];
  sph_pkg::wide_t  dd_q  [NS+1];
  logic [NS-1:0]   qb_q  [NS+1];
  logic            sn_q  [NS+1];
  logic            zr_q  [NS+1];
  logic [31:0]     res_q;
  logic [31:0]     res_d;

  always_ff @(posedge clk_i) begin
    rem_q[0] <= num_i;
    dd_q[0]  <= den_i;
    qb_q[0]  <= '0;
    sn_q[0]  <= sneg_i;
    zr_q[0]  <= zero_i;
  end

  for (genvar s = 0; s < NS; s++) begin : g_stage
    localparam int J = NS - 1 - s;
    sph_pkg::wide_t t;
    logic           ge;
    assign t  = dd_q[s] << J;
    assign ge = (rem_q[s] >= t);
    always_ff @(posedge clk_i) begin
      rem_q[s+1] <= ge ? (rem_q[s] - t) : rem_q[s];
      dd_q[s+1]  <= dd_q[s];
      qb_q[s+1]  <= {qb_q[s][NS-2:0], ge};
      sn_q[s+1]  <= sn_q[s];
      zr_q[s+1]  <= zr_q[s];
    end
  end

  always_comb begin
    logic [31:0] lim;
    logic [31:0] m;
    lim = sn_q[NS] ? sph_pkg::SAT_NEG : sph_pkg::SAT_POS;
    if (qb_q[NS][NS-1] || (qb_q[NS][31:0] > lim)) begin
      m = lim;
    end else begin
      m = qb_q[NS][31:0];
    end
    res_o = res_q;
    if (zr_q[NS]) begin
      m = 32'd0;
    end
    res_d = sn_q[NS] ? (~m + 32'd1) : m;
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

endmodule

`default_nettype wire

@@ design/sph_back.sv @@
// ----------------------------------------------------------------------------
// sph_back: kernel evaluation pipeline
// Squares, root, radius powers, numerator products and three dividers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sph_back (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic [sph_pkg::HW-1:0] radius_i,
  input  logic                   item_valid_i,
  input  sph_pkg::item_t         item_i,
  output logic                   rsp_valid_o,
  output sph_pkg::rsp_t          rsp_o
);

  localparam int HW = sph_pkg::HW;
  localparam int NL3 = sph_pkg::NLANE;
  localparam int RM = HW + 3;

  typedef struct packed {
    logic [1:0]     npow;
    logic           flip;
    logic           zero;
    logic [NL3-1:0] neg;
    logic [HW-1:0]  u;
  } side_t;

  // pi * h^6, recomputed from the radius register through registered products
  logic [2*HW-1:0]  hh_q;
  sph_pkg::wpart_t  ph_part_q [6];
  sph_pkg::wide_t   ph_q      [6];

  always_ff @(posedge clk_i) begin
    hh_q         <= radius_i * radius_i;
    ph_part_q[0] <= sph_pkg::wmul_split(sph_pkg::PI_W, 32'(radius_i));
    for (int t = 1; t < 6; t++) begin
      ph_part_q[t] <= sph_pkg::wmul_split(ph_q[t-1], 32'(radius_i));
    end
    for (int t = 0; t < 6; t++) begin
      ph_q[t] <= ph_part_q[t].ev + ph_part_q[t].od;
    end
  end

  // squares
  logic            v1_q;
  sph_pkg::item_t  it1_q;
  logic [2*HW-1:0] sq_q [NL3];

  always_ff @(posedge clk_i) begin
    it1_q <= item_i;
    for (int i = 0; i < NL3; i++) begin
      sq_q[i] <= item_i.mag[i] * item_i.mag[i];
    end
  end

  // root pipeline, one result bit per stage
  logic            sr_vld_q  [HW+1];
  sph_pkg::item_t  sr_it_q   [HW+1];
  logic [2*HW-1:0] sr_v_q    [HW+1];
  logic [RM-1:0]   sr_rem_q  [HW+1];
  logic [HW-1:0]   sr_root_q [HW+1];
  logic [2*HW+1:0] r2_full;
  sph_pkg::item_t  it1_z;

  always_comb begin
    r2_full = {2'b00, sq_q[0]} + {2'b00, sq_q[1]} + {2'b00, sq_q[2]};
    it1_z   = it1_q;
    if (r2_full == '0 || r2_full > {2'b00, hh_q}) begin
      it1_z.zero = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    sr_it_q[0]   <= it1_z;
    sr_v_q[0]    <= r2_full[2*HW-1:0];
    sr_rem_q[0]  <= '0;
    sr_root_q[0] <= '0;
  end

  for (genvar s = 0; s < HW; s++) begin : g_sqrt
    localparam int B = HW - 1 - s;
    logic [RM+1:0] rem_x;
    logic [HW+1:0] trial;
    logic          ge;
    assign rem_x = {sr_rem_q[s], sr_v_q[s][2*B+1 -: 2]};
    assign trial = {sr_root_q[s], 2'b01};
    assign ge    = (rem_x >= (RM+2)'(trial));
    always_ff @(posedge clk_i) begin
      sr_rem_q[s+1]  <= ge ? RM'(rem_x - (RM+2)'(trial)) : RM'(rem_x);
      sr_root_q[s+1] <= {sr_root_q[s][HW-2:0], ge};
      sr_v_q[s+1]    <= sr_v_q[s];
      sr_it_q[s+1]   <= sr_it_q[s];
    end
  end

  // u = h - r, numerator bases, denominator split
  side_t           side_q [7];
  logic            vld_q  [7];
  sph_pkg::wide_t  base_q [NL3];
  sph_pkg::wpart_t dpart_q;
  sph_pkg::wide_t  dn_q   [6];
  sph_pkg::wpart_t mp_q   [sph_pkg::NSTEP][NL3];
  sph_pkg::wide_t  mw_q   [sph_pkg::NSTEP][NL3];

  always_ff @(posedge clk_i) begin
    sph_pkg::item_t it;
    logic [5:0]     kc;
    it = sr_it_q[HW];
    kc = it.k45 ? sph_pkg::K_DERIV : sph_pkg::K_VALUE;
    side_q[0].npow <= it.npow;
    side_q[0].flip <= it.flip;
    side_q[0].zero <= it.zero;
    side_q[0].neg  <= it.neg;
    side_q[0].u    <= radius_i - sr_root_q[HW];
    for (int i = 0; i < NL3; i++) begin
      base_q[i] <= sph_pkg::wide_t'({6'd0, it.mag[i]} * {31'd0, kc});
    end
    dpart_q <= sph_pkg::wmul_split(ph_q[5], 32'(sr_root_q[HW]));
    dn_q[0] <= dpart_q.ev + dpart_q.od;
    for (int k = 1; k < 6; k++) begin
      dn_q[k] <= dn_q[k-1];
    end
    for (int k = 1; k < 7; k++) begin
      side_q[k] <= side_q[k-1];
    end
  end

  for (genvar t = 0; t < sph_pkg::NSTEP; t++) begin : g_num
    logic [31:0] mul;
    assign mul = (side_q[2*t].npow > 2'(t)) ? 32'(side_q[2*t].u) : 32'd1;
    always_ff @(posedge clk_i) begin
      for (int i = 0; i < NL3; i++) begin
        if (t == 0) begin
          mp_q[t][i] <= sph_pkg::wmul_split(base_q[i], mul);
        end else begin
          mp_q[t][i] <= sph_pkg::wmul_split(mw_q[(t == 0) ? 0 : t-1][i], mul);
        end
        mw_q[t][i] <= mp_q[t][i].ev + mp_q[t][i].od;
      end
    end
  end

  // dividers
  sph_pkg::wide_t num  [NL3];
  logic [31:0]    res  [NL3];
  logic           dv_q [sph_pkg::DIV_LAT];

  always_comb begin
    for (int i = 0; i < NL3; i++) begin
      case (side_q[6].npow)
        2'd3:    num[i] = mw_q[2][i] << sph_pkg::SH3;
        2'd2:    num[i] = mw_q[2][i] << sph_pkg::SH2;
        default: num[i] = mw_q[2][i] << sph_pkg::SH0;
      endcase
    end
  end

  for (genvar i = 0; i < NL3; i++) begin : g_div
    sph_div u_div (
      .clk_i  (clk_i),
      .num_i  (num[i]),
      .den_i  (dn_q[5]),
      .sneg_i (side_q[6].neg[i] ^ side_q[6].flip),
      .zero_i (side_q[6].zero),
      .res_o  (res[i])
    );
  end

  // valid tracking over the whole fixed-latency pipe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      for (int s = 0; s <= HW; s++) begin
        sr_vld_q[s] <= 1'b0;
      end
      for (int k = 0; k < 7; k++) begin
        vld_q[k] <= 1'b0;
      end
      for (int k = 0; k < sph_pkg::DIV_LAT; k++) begin
        dv_q[k] <= 1'b0;
      end
    end else begin
      v1_q        <= item_valid_i;
      sr_vld_q[0] <= v1_q;
      for (int s = 1; s <= HW; s++) begin
        sr_vld_q[s] <= sr_vld_q[s-1];
      end
      vld_q[0] <= sr_vld_q[HW];
      for (int k = 1; k < 7; k++) begin
        vld_q[k] <= vld_q[k-1];
      end
      dv_q[0] <= vld_q[6];
      for (int k = 1; k < sph_pkg::DIV_LAT; k++) begin
        dv_q[k] <= dv_q[k-1];
      end
    end
  end

  assign rsp_valid_o = dv_q[sph_pkg::DIV_LAT-1];
  assign rsp_o.out_x = res[0];
  assign rsp_o.out_y = res[1];
  assign rsp_o.out_z = res[2];

endmodule

`default_nettype wire

@@ design/sph_spiky_kernel_vector_core.sv @@
// ----------------------------------------------------------------------------
// sph_spiky_kernel_vector_core: spiky kernel vector for 3D particle pairs
// Scales the unit difference vector by the kernel value, gradient or
// laplacian scalar, in saturated signed fixed point.
// ----------------------------------------------------------------------------
//
//  channel    | signals                    | direction | flow
//  -----------+----------------------------+-----------+-------------------
//  request    | start, busy, req_i         | in        | taken: start & !busy
//  result     | result_valid_o, rsp_o      | out       | one-cycle strobe
//  config     | cfg_we_i, cfg_wdata_i      | in        | radius, written at once
//
//  One request per cycle sustained. Each accepted request passes the front
//  register, the queue, the squares, the root pipeline, the wide products
//  and the dividers; the strobe rises as its result leaves the divider
//  output register.
//  busy only rises if the two-entry queue fills; the back never stalls, since
//  the receiver takes every result.
//  Reset clears control and loads the radius with 1.0; radius writes are to be
//  made only with the block empty; the block itself does not enforce this.
//
`timescale 1ns / 1ps
`default_nettype none

module sph_spiky_kernel_vector_core (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [sph_pkg::HW-1:0] cfg_wdata_i,
  input  logic                   start,
  output logic                   busy,
  input  sph_pkg::req_t          req_i,
  output logic                   result_valid_o,
  output sph_pkg::rsp_t          rsp_o
);

  logic [sph_pkg::HW-1:0] radius_q;
  logic                   push;
  logic                   q_full;
  logic                   q_valid;
  sph_pkg::item_t         fr_item;
  sph_pkg::item_t         q_item;

  // support radius h
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q <= sph_pkg::RADIUS_RST;
    end else if (cfg_we_i) begin
      radius_q <= cfg_wdata_i;
    end
  end

  // front: differences, range check, op decode
  sph_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .radius_i (radius_q),
    .start_i  (start),
    .req_i    (req_i),
    .q_full_i (q_full),
    .busy_o   (busy),
    .push_o   (push),
    .item_o   (fr_item)
  );

  sph_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (fr_item),
    .full_o  (q_full),
    .valid_o (q_valid),
    .item_o  (q_item)
  );

  // back: always ready, drains the queue each cycle
  sph_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .radius_i     (radius_q),
    .item_valid_i (q_valid),
    .item_i       (q_item),
    .rsp_valid_o  (result_valid_o),
    .rsp_o        (rsp_o)
  );

endmodule

`default_nettype wire

@@ dv/tb.sv @@
// ----------------------------------------------------------------------------
// tb: self-checking bench for the spiky kernel vector core
// Directed rows, then random particle pairs across several radius settings,
// scored against hand-typed answers or an exact wide-integer predictor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import sph_pkg::*;

  localparam int  CYCLE_LIMIT = 2_000_000;
  localparam int  DRAIN_WAIT  = 100;       // covers the full pipe
  localparam int  RAND_ITEMS  = 1950;
  localparam int  BW          = 384;       // wide enough for num and den

  // one directed row: radius, request, and an optional hand-typed answer
  typedef struct {
    logic [HW-1:0] h;
    req_t          rq;
    bit            typed;
    rsp_t          ans;
  } row_t;

  logic          clk_i;
  logic          rst_ni;
  logic          cfg_we_i;
  logic [HW-1:0] cfg_wdata_i;
  logic          start;
  logic          busy;
  req_t          req_i;
  logic          result_valid_o;
  rsp_t          rsp_o;

  rsp_t          pending_vectors[$];
  row_t          rows[$];
  logic [HW-1:0] radius;          // mirror of the radius register
  int            mismatches;
  bit            failed;
  int            cycles;

  sph_spiky_kernel_vector_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .start         (start),
    .busy          (busy),
    .req_i         (req_i),
    .result_valid_o(result_valid_o),
    .rsp_o         (rsp_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // floor square root, bit-serial
  function automatic logic [63:0] root64(input logic [63:0] v);
    logic [63:0] res;
    logic [63:0] b;
    res = '0;
    b   = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v   = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  // expected kernel vector for one request at radius h
  function automatic rsp_t spiky_vector(input req_t rq, input logic [HW-1:0] h);
    logic signed [32:0] d;
    logic [32:0]        mag[3];
    bit                 neg[3];
    bit                 near;
    bit                 flip;
    bit                 sneg;
    logic [63:0]        r2;
    logic [63:0]        hh;
    logic [63:0]        r;
    logic [63:0]        u;
    logic [BW-1:0]      den;
    logic [BW-1:0]      num;
    logic [BW-1:0]      q;
    logic [BW-1:0]      lim;
    logic [31:0]        lane[3];
    logic [31:0]        src[3];
    logic [31:0]        dst[3];
    int                 npow;
    int                 k;
    rsp_t               o;
    src  = '{rq.src_x, rq.src_y, rq.src_z};
    dst  = '{rq.dst_x, rq.dst_y, rq.dst_z};
    lane = '{32'd0, 32'd0, 32'd0};
    near = 1'b1;
    r2   = '0;
    for (int i = 0; i < 3; i++) begin
      d      = {src[i][31], src[i]} - {dst[i][31], dst[i]};
      neg[i] = d < 0;
      mag[i] = neg[i] ? -d : d;
      if (mag[i] > {2'b00, h}) near = 1'b0;
    end
    if (near) begin
      for (int i = 0; i < 3; i++) r2 = r2 + 64'(mag[i]) * 64'(mag[i]);
      hh = 64'(h) * 64'(h);
      case (rq.opcode)
        OP_VALUE: begin npow = 3; k = 15; flip = 1'b0; end
        OP_GRAD:  begin npow = 2; k = 45; flip = 1'b1; end
        OP_LAP:   begin npow = 0; k = 45; flip = 1'b0; end
        default:  begin npow = -1; k = 0; flip = 1'b0; end
      endcase
      if (r2 != 0 && r2 <= hh && npow >= 0) begin
        r   = root64(r2);
        u   = 64'(h) - r;
        den = BW'(PI_Q60) * BW'(r);
        for (int j = 0; j < 6; j++) den = den * BW'(h);
        for (int i = 0; i < 3; i++) begin
          if (mag[i] != 0) begin
            num = BW'(mag[i]) * BW'(k);
            for (int j = 0; j < npow; j++) num = num * BW'(u);
            num  = num << (FRAC_BITS * (7 - npow) + 60);
            q    = num / den;
            sneg = neg[i] != flip;
            lim  = sneg ? BW'(64'h8000_0000) : BW'(64'h7FFF_FFFF);
            if (q > lim) q = lim;
            lane[i] = sneg ? -q[31:0] : q[31:0];
          end
        end
      end
    end
    o.out_x = lane[0];
    o.out_y = lane[1];
    o.out_z = lane[2];
    return o;
  endfunction

  task automatic add_row(input logic [HW-1:0] h, input logic [1:0] op,
                         input logic [31:0] sx, input logic [31:0] sy,
                         input logic [31:0] sz, input logic [31:0] dx,
                         input logic [31:0] dy, input logic [31:0] dz,
                         input bit typed, input logic [31:0] ex,
                         input logic [31:0] ey, input logic [31:0] ez);
    row_t w;
    w.h     = h;
    w.rq    = '{opcode: op, src_x: sx, src_y: sy, src_z: sz,
                dst_x: dx, dst_y: dy, dst_z: dz};
    w.typed = typed;
    w.ans   = '{out_x: ex, out_y: ey, out_z: ez};
    rows.push_back(w);
  endtask

  // radius change: only with nothing in flight
  task automatic set_radius(input logic [HW-1:0] h);
    while (pending_vectors.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= h;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    radius = h;
  endtask

  // present one request and hold it until the core takes it; the expected
  // vector is queued on the accepting edge
  task automatic send(input req_t rq, input bit typed, input rsp_t ans);
    int gap;
    int pick;
    start <= 1'b1;
    req_i <= rq;
    do @(posedge clk_i); while (!(start && !busy));
    pending_vectors.push_back(typed ? ans : spiky_vector(rq, radius));
    pick = $urandom_range(0, 99);
    if (pick < 55) gap = 0;                              // back to back
    else if (pick < 92) gap = $urandom_range(1, 3);
    else gap = $urandom_range(10, 60);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // random request: mostly pairs inside the support, some noise
  function automatic req_t pair_in(input logic [HW-1:0] h);
    req_t        rq;
    logic [31:0] span;
    logic [31:0] c;
    logic [31:0] dst[3];
    logic [31:0] src[3];
    int          kind;
    kind = $urandom_range(0, 99);
    rq.opcode = ($urandom_range(0, 19) == 0) ? 2'd3 : 2'($urandom_range(0, 2));
    span = ($urandom_range(0, 3) == 0) ? 32'(h) : ((32'(h) >> 1) | 32'd1);
    for (int i = 0; i < 3; i++) begin
      dst[i] = $urandom;
      if (kind < 75) begin
        c      = $urandom_range(0, span);
        src[i] = $urandom_range(0, 1) ? dst[i] + c : dst[i] - c;
      end else if (kind < 90) begin
        src[i] = $urandom;
      end else begin
        src[i] = dst[i];                // zero difference on this axis
      end
    end
    rq.src_x = src[0]; rq.src_y = src[1]; rq.src_z = src[2];
    rq.dst_x = dst[0]; rq.dst_y = dst[1]; rq.dst_z = dst[2];
    return rq;
  endfunction

  // scoreboard: every strobe is matched to the oldest expectation
  always @(posedge clk_i) begin
    rsp_t want;
    if (rst_ni && result_valid_o) begin
      if (pending_vectors.size() == 0) begin
        failed = 1'b1;
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", rsp_o);
      end else begin
        want = pending_vectors.pop_front();
        if (rsp_o.out_x !== want.out_x || rsp_o.out_y !== want.out_y ||
            rsp_o.out_z !== want.out_z) begin
          failed = 1'b1;
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected %h %h %h got %h %h %h",
                     want.out_x, want.out_y, want.out_z,
                     rsp_o.out_x, rsp_o.out_y, rsp_o.out_z);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    logic [HW-1:0] hset[6];
    rsp_t          none;
    none        = '0;
    cycles      = 0;
    mismatches  = 0;
    failed      = 1'b0;
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_wdata_i = '0;
    start       = 1'b0;
    req_i       = '0;
    radius      = RADIUS_RST;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // at reset radius 1.0
    add_row(65536, OP_VALUE, 5, 5, 5, 5, 5, 5, 1, 0, 0, 0);          // zero diff
    add_row(65536, OP_VALUE, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    add_row(65536, OP_GRAD, 0, -1, 0, 0, 0, 0, 0, 0, 0, 0);
    add_row(65536, OP_LAP, 0, 0, 32'h8000, 0, 0, 0, 0, 0, 0, 0);
    add_row(65536, OP_GRAD, 65536, 0, 0, 0, 0, 0, 1, 0, 0, 0);       // r = h
    add_row(65536, OP_VALUE, 0, 0, 65536, 0, 0, 0, 1, 0, 0, 0);
    add_row(65536, OP_LAP, 0, 65536, 0, 0, 0, 0, 0, 0, 0, 0);
    add_row(65536, OP_VALUE, 65537, 0, 0, 0, 0, 0, 1, 0, 0, 0);      // axis past h
    add_row(65536, OP_LAP, 40000, 40000, 40000, 0, 0, 0, 1, 0, 0, 0); // r past h
    add_row(65536, 2'd3, 1, 1, 1, 0, 0, 0, 1, 0, 0, 0);              // unused op
    add_row(65536, OP_LAP, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
            32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1, 0, 0, 0);
    add_row(65536, OP_GRAD, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
            32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1, 0, 0, 0);
    add_row(65536, OP_VALUE, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
            32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 1, 0, 0, 0);
    add_row(65536, OP_GRAD, -300, 200, -100, 0, 0, 0, 0, 0, 0, 0);
    // tiniest radius: laplacian saturates both ways
    add_row(1, OP_LAP, 1, 0, 0, 0, 0, 0, 1, 32'h7FFF_FFFF, 0, 0);
    add_row(1, OP_LAP, -1, 0, 0, 0, 0, 0, 1, 32'h8000_0000, 0, 0);
    add_row(1, OP_GRAD, 0, 1, 0, 0, 0, 0, 1, 0, 0, 0);
    add_row(1, OP_VALUE, 0, 0, 0, 0, 0, 1, 1, 0, 0, 0);
    // radius zero
    add_row(0, OP_LAP, 1, 0, 0, 0, 0, 0, 1, 0, 0, 0);
    add_row(0, OP_LAP, 9, 9, 9, 9, 9, 9, 1, 0, 0, 0);
    // largest radius
    add_row(31'h7FFF_FFFF, OP_LAP, 32'h7FFF_FFFF, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    add_row(31'h7FFF_FFFF, OP_GRAD, 1000, -2000, 3000, 0, 0, 0, 0, 0, 0, 0);
    add_row(31'h7FFF_FFFF, OP_VALUE, 32'h4000_0000, 0, 0, 32'hC000_0001, 0, 0,
            0, 0, 0, 0);

    foreach (rows[i]) begin
      if (rows[i].h != radius) begin
        start <= 1'b0;
        set_radius(rows[i].h);
      end
      send(rows[i].rq, rows[i].typed, rows[i].ans);
    end

    // random pairs over a spread of radii; each change drains the core
    hset = '{31'h7FFF_FFFF, 31'd1, 31'd65536, 31'($urandom_range(2, 4096)),
             31'($urandom_range(4096, 1 << 24)), 31'($urandom)};
    for (int p = 0; p < 6; p++) begin
      start <= 1'b0;
      set_radius(hset[p]);
      for (int n = 0; n < RAND_ITEMS / 6; n++) send(pair_in(radius), 1'b0, none);
    end
    start <= 1'b0;

    while (pending_vectors.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (!failed) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
design/sph_pkg.sv
design/sph_front.sv
design/sph_queue.sv
design/sph_div.sv
design/sph_back.sv
design/sph_spiky_kernel_vector_core.sv
dv/tb.sv
